// ===== rtl/ism_pkg.sv =====
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, sizes and codes for the integer stack machine.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 4;
  localparam int STATUS_W    = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FN_PUSH = 4'd0;
  localparam func_t FN_ADD  = 4'd1;
  localparam func_t FN_SUB  = 4'd2;
  localparam func_t FN_MUL  = 4'd3;
  localparam func_t FN_DIV  = 4'd4;
  localparam func_t FN_MAX  = 4'd5;
  localparam func_t FN_MIN  = 4'd6;
  localparam func_t FN_NEG  = 4'd7;
  localparam func_t FN_DUP  = 4'd8;
  localparam func_t FN_SWAP = 4'd9;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

endpackage

// ===== rtl/ism_ram.sv =====
// ----------------------------------------------------------------------------
// ism_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/integer_stack_machine.sv =====
// ----------------------------------------------------------------------------
// integer_stack_machine
// 32-bit signed integer stack executing one instruction per input beat.
// ----------------------------------------------------------------------------
// The top of stack lives in a register and the entries below it in a
// single-port-write RAM, so each instruction needs at most one RAM read.
// The block takes one instruction at a time and holds in_stall until the
// result is loaded into the output register. Push, negate, duplicate,
// unused selectors and every underflow or overflow go from decode straight
// to the done state. The binary operations, swap and divide by zero pass
// through an execute state as well, for the registered RAM read of the
// second entry. Divide then runs the restoring divider, retiring one
// quotient bit per cycle, before the done state. A finished result waits
// in the output register while the next instruction is accepted; if that
// register is still held by out_stall, the block waits before loading it.
// ----------------------------------------------------------------------------
module integer_stack_machine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ism_pkg::func_t    func,
  input  ism_pkg::data_t    operand,
  output logic              out_valid,
  input  logic              out_stall,
  output ism_pkg::data_t    top_value,
  output ism_pkg::ptr_t     depth,
  output ism_pkg::status_t  status
);
  import ism_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  func_t      cmd_func;
  data_t      cmd_opnd;
  ptr_t       sp;
  data_t      top;
  status_t    stat;

  data_t      div_rem;
  data_t      div_quo;
  data_t      div_den;
  logic       div_neg;
  logic [4:0] div_cnt;

  ptr_t       sp_m1;
  ptr_t       sp_m2;
  logic       we;
  addr_t      waddr;
  data_t      rd;
  logic [DATA_W:0] div_shift;
  logic [DATA_W:0] div_diff;
  data_t      div_q_step;
  data_t      prod;

  assign sp_m1 = sp - PTR_W'(1);
  assign sp_m2 = sp - PTR_W'(2);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = sp_m1[ADDR_W-1:0];
    if (state == S_DEC && (cmd_func == FN_PUSH || cmd_func == FN_DUP) &&
        sp != '0 && sp != PTR_W'(STACK_DEPTH)) begin
      we = 1'b1;
    end
    if (state == S_EXE && cmd_func == FN_SWAP) begin
      we    = 1'b1;
      waddr = sp_m2[ADDR_W-1:0];
    end
  end

  ism_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .raddr (sp_m2[ADDR_W-1:0]),
    .rdata (rd)
  );

  assign div_shift  = {div_rem, div_quo[DATA_W-1]};
  assign div_diff   = div_shift - {1'b0, div_den};
  assign div_q_step = {div_quo[DATA_W-2:0], ~div_diff[DATA_W]};
  assign prod       = top * rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_func <= func;
            cmd_opnd <= operand;
            state    <= S_DEC;
          end
        end
        S_DEC: begin
          case (cmd_func) inside
            FN_PUSH: begin
              state <= S_DONE;
              if (sp == PTR_W'(STACK_DEPTH)) begin
                stat <= ST_OVER;
              end else begin
                stat <= ST_OK;
                top  <= cmd_opnd;
                sp   <= sp + PTR_W'(1);
              end
            end
            FN_NEG: begin
              state <= S_DONE;
              if (sp == '0) begin
                stat <= ST_UNDER;
              end else begin
                stat <= ST_OK;
                top  <= '0 - top;
              end
            end
            FN_DUP: begin
              state <= S_DONE;
              if (sp == '0) begin
                stat <= ST_UNDER;
              end else if (sp == PTR_W'(STACK_DEPTH)) begin
                stat <= ST_OVER;
              end else begin
                stat <= ST_OK;
                sp   <= sp + PTR_W'(1);
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MAX, FN_MIN, FN_SWAP: begin
              if (sp < PTR_W'(2)) begin
                stat  <= ST_UNDER;
                state <= S_DONE;
              end else begin
                stat  <= ST_OK;
                state <= S_EXE;
              end
            end
            default: begin
              stat  <= ST_OK;
              state <= S_DONE;
            end
          endcase
        end
        S_EXE: begin
          case (cmd_func)
            FN_ADD: begin
              top   <= top + rd;
              sp    <= sp_m1;
              state <= S_DONE;
            end
            FN_SUB: begin
              top   <= top - rd;
              sp    <= sp_m1;
              state <= S_DONE;
            end
            FN_MUL: begin
              top   <= prod;
              sp    <= sp_m1;
              state <= S_DONE;
            end
            FN_MAX: begin
              top   <= ($signed(top) > $signed(rd)) ? top : rd;
              sp    <= sp_m1;
              state <= S_DONE;
            end
            FN_MIN: begin
              top   <= ($signed(rd) > $signed(top)) ? top : rd;
              sp    <= sp_m1;
              state <= S_DONE;
            end
            FN_SWAP: begin
              top   <= rd;
              state <= S_DONE;
            end
            FN_DIV: begin
              if (rd == '0) begin
                stat  <= ST_DIVZ;
                state <= S_DONE;
              end else begin
                div_rem <= '0;
                div_quo <= top[DATA_W-1] ? '0 - top : top;
                div_den <= rd[DATA_W-1] ? '0 - rd : rd;
                div_neg <= top[DATA_W-1] ^ rd[DATA_W-1];
                div_cnt <= '0;
                state   <= S_DIV;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DIV: begin
          div_rem <= div_diff[DATA_W] ? div_shift[DATA_W-1:0] : div_diff[DATA_W-1:0];
          div_quo <= div_q_step;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            top   <= div_neg ? '0 - div_q_step : div_q_step;
            sp    <= sp_m1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            top_value <= (sp == '0) ? '0 : top;
            depth     <= sp;
            status    <= stat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth == '0 |-> top_value == '0)
    else $error("empty stack with nonzero top");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_den != '0)
    else $error("divider running with zero divisor");

  a_err_depth: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && stat != ST_OK |=> sp == $past(sp))
    else $error("stack pointer moved on error");
`endif

endmodule

// ===== tb/sv/ism_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_checker
// Watches both channels of the integer stack machine, keeps its own copy of
// the stack, predicts the result of every accepted instruction and compares
// each returned beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ism_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  ism_pkg::func_t   func,
  input  ism_pkg::data_t   operand,
  input  logic             out_valid,
  input  logic             out_stall,
  input  ism_pkg::data_t   top_value,
  input  ism_pkg::ptr_t    depth,
  input  ism_pkg::status_t status,
  output int               errors,
  output int               pending,
  output int               results
);
  import ism_pkg::*;

  typedef struct packed {
    data_t   top;
    ptr_t    depth;
    status_t st;
  } stack_view_t;

  data_t       stack_mem [STACK_DEPTH];
  int          sp;
  stack_view_t views_due [$];

  function automatic data_t sdiv(data_t a, data_t b);
    data_t ma, mb, q;
    ma = a[DATA_W-1] ? -a : a;
    mb = b[DATA_W-1] ? -b : b;
    q  = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic stack_view_t exec_instr(func_t f, data_t opnd);
    stack_view_t v;
    data_t       a, b, r;
    status_t     st;
    st = ST_OK;
    r  = '0;
    case (f)
      FN_PUSH: begin
        if (sp >= STACK_DEPTH) st = ST_OVER;
        else begin
          stack_mem[sp] = opnd;
          sp++;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MAX, FN_MIN: begin
        if (sp < 2) st = ST_UNDER;
        else begin
          a = stack_mem[sp-1];
          b = stack_mem[sp-2];
          case (f)
            FN_ADD: r = a + b;
            FN_SUB: r = a - b;
            FN_MUL: r = a * b;
            FN_DIV: begin
              if (b == '0) st = ST_DIVZ;
              else r = sdiv(a, b);
            end
            FN_MAX: r = ($signed(a) > $signed(b)) ? a : b;
            default: r = ($signed(b) > $signed(a)) ? a : b;
          endcase
          if (st == ST_OK) begin
            stack_mem[sp-2] = r;
            sp--;
          end
        end
      end
      FN_NEG: begin
        if (sp < 1) st = ST_UNDER;
        else stack_mem[sp-1] = -stack_mem[sp-1];
      end
      FN_DUP: begin
        if (sp < 1) st = ST_UNDER;
        else if (sp >= STACK_DEPTH) st = ST_OVER;
        else begin
          stack_mem[sp] = stack_mem[sp-1];
          sp++;
        end
      end
      FN_SWAP: begin
        if (sp < 2) st = ST_UNDER;
        else begin
          a = stack_mem[sp-1];
          stack_mem[sp-1] = stack_mem[sp-2];
          stack_mem[sp-2] = a;
        end
      end
      default: ;
    endcase
    v.top   = (sp > 0) ? stack_mem[sp-1] : '0;
    v.depth = ptr_t'(sp);
    v.st    = st;
    return v;
  endfunction

  initial begin
    errors  = 0;
    results = 0;
    pending = 0;
    sp      = 0;
  end

  always @(posedge clk) begin
    stack_view_t exp_v;
    if (rst) begin
      sp = 0;
      views_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results++;
        if (views_due.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_v = views_due.pop_front();
          if (top_value !== exp_v.top) begin
            $error("top_value: expected %0d, got %0d", $signed(exp_v.top), $signed(top_value));
            errors++;
          end
          if (depth !== exp_v.depth) begin
            $error("depth: expected %0d, got %0d", exp_v.depth, depth);
            errors++;
          end
          if (status !== exp_v.st) begin
            $error("status: expected %0d, got %0d", exp_v.st, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) views_due.push_back(exec_instr(func, operand));
    end
    pending = views_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the integer stack machine: directed corner instructions, then
// random instruction streams under four pacing modes, a long output hold-off,
// a full-stack fill with overflow and a drain. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ism_pkg::*;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  func_t   func      = FN_PUSH;
  data_t   operand   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  data_t   top_value;
  ptr_t    depth;
  status_t status;

  int errors, pending, results;
  int send_pct = 0;
  int rcv_pct  = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent = 0;

  localparam data_t INT_MIN = 32'h8000_0000;
  localparam data_t INT_MAX = 32'h7fff_ffff;

  always #5 clk = ~clk;

  integer_stack_machine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .operand(operand),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .depth(depth), .status(status)
  );

  ism_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .operand(operand),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .depth(depth), .status(status),
    .errors(errors), .pending(pending), .results(results)
  );

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  task automatic set_mode(int m);
    case (m)
      1: begin send_pct = 86; rcv_pct = 0; end
      2: begin send_pct = 0; rcv_pct = 86; end
      3: begin send_pct = 32; rcv_pct = 32; end
      default: begin send_pct = 0; rcv_pct = 0; end
    endcase
  endtask

  task automatic send_instr(func_t f, data_t v);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    operand  <= v;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic data_t rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return INT_MIN;
      4: return INT_MAX;
      5, 6: return data_t'($signed($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic func_t rand_func(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return FN_PUSH;
    if (r < push_pct + 40) return func_t'($urandom_range(FN_MIN, FN_ADD));
    if (r < push_pct + 48) return FN_NEG;
    if (r < push_pct + 55) return FN_DUP;
    if (r < 96) return FN_SWAP;
    return func_t'($urandom_range(15, 10));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_instr(FN_ADD, '0);
    send_instr(FN_NEG, '0);
    send_instr(FN_DUP, '0);
    send_instr(FN_SWAP, '0);
    send_instr(func_t'(15), '1);
    send_instr(FN_PUSH, INT_MAX);
    send_instr(FN_PUSH, 32'd1);
    send_instr(FN_ADD, '0);
    send_instr(FN_PUSH, '1);
    send_instr(FN_PUSH, INT_MIN);
    send_instr(FN_DIV, '0);
    send_instr(FN_NEG, '0);
    send_instr(FN_PUSH, '0);
    send_instr(FN_SWAP, '0);
    send_instr(FN_DIV, '0);
    send_instr(FN_PUSH, -32'sd7);
    send_instr(FN_PUSH, 32'd2);
    send_instr(FN_DIV, '0);
    send_instr(FN_SUB, '0);
    send_instr(FN_MUL, '0);
    send_instr(FN_DUP, '0);
    send_instr(FN_MAX, '0);
    send_instr(FN_PUSH, 32'd5);
    send_instr(FN_MIN, '0);
    send_instr(func_t'(10), '0);

    for (int m = 0; m < 4; m++) begin
      set_mode(m);
      repeat (150) send_instr(rand_func(32), rand_operand());
    end

    set_mode(0);
    hold_req++;
    repeat (40) send_instr(rand_func(40), rand_operand());
    wait_drained();
    repeat ($urandom_range(20, 1)) @(posedge clk);

    set_mode(3);
    repeat (1030) send_instr(FN_PUSH, rand_operand());
    repeat (20) send_instr(($urandom_range(1)) ? FN_DUP : FN_PUSH, rand_operand());
    for (int m = 0; m < 4; m++) begin
      set_mode(m);
      repeat (50) send_instr(rand_func(8), rand_operand());
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Sent %0d instructions, checked %0d result beats, over four pacing modes,",
             sent, results);
    $display("an output hold-off, and a full-stack fill with overflow and drain.");
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ism_pkg.sv
rtl/ism_ram.sv
rtl/integer_stack_machine.sv
tb/sv/ism_checker.sv
tb/sv/tb_top.sv
